FILE: hw/rtl/mrfc_pkg.sv
// Package for the modified relay feedback controller.
// Holds the input command codes, the register map and the fixed field widths.
// Depends on nothing; imported by modified_relay_feedback_controller.
package mrfc_pkg;

  // Command codes carried on the cmd field of an input word.
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Register indexes; register i lies at byte address 4*i.
  typedef enum logic [2:0] {
    REG_BETA        = 3'd0,
    REG_AMPLITUDE   = 3'd1,
    REG_BIAS        = 3'd2,
    REG_PEAK_CONF   = 3'd3,
    REG_HOLDOFF     = 3'd4
  } reg_idx_t;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int BETA_W    = 16;
  localparam int AMP_W     = 15;
  localparam int BIAS_W    = 16;
  localparam int CONF_W    = 8;
  localparam int HOLD_W    = 16;
  localparam int COMMAND_W = 17;

  localparam logic [CONF_W-1:0] PEAK_CONF_RESET = 8'd3;
  localparam logic [HOLD_W-1:0] HOLD_MAX        = 16'hFFFF;

endpackage

FILE: hw/rtl/modified_relay_feedback_controller.sv
// Top level of the modified relay feedback controller.
// One module: register file, controller state, threshold compare and output skid.
// Depends on mrfc_pkg.
//
// Usage:
// The input channel (in_valid, in_stall, cmd, err) carries one word per
// accepted handshake. A word with cmd set to sample carries an error sample
// and yields exactly one result word on the output channel (out_valid,
// out_stall, command, relay_high). A millisecond tick advances the holdoff
// timer and a controller clear returns the relay logic to its first-sample
// condition; neither produces a result word.
// The result of an accepted sample is registered into the output register,
// or into the skid stage while the output register holds a word not yet
// taken. Throughput is one word per cycle while in_stall is low, set by the
// single registered pass that holds the multiplier and the threshold compare.
// The output register is backed by a one-word skid stage, so the block keeps
// taking words while a result waits to be taken; in_stall rises only once
// the skid stage is full, and falls again when the receiver takes a word.
// The user writes the APB port only while idle; the block does not enforce it.
// Reset (rst, synchronous, active high) empties both output stages, returns
// every register to its documented reset value and puts the controller back
// to waiting for its first sample with the holdoff timer at zero.
module modified_relay_feedback_controller #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port; pready is always high
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mrfc_pkg::ADDR_W-1:0]         paddr,
  input  logic [mrfc_pkg::DATA_W-1:0]         pwdata,
  output logic [mrfc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]      err,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mrfc_pkg::COMMAND_W-1:0] command,
  output logic                                relay_high
);

  import mrfc_pkg::*;

  // Product of beta and a stored peak, and the width used for the compare,
  // which holds err scaled by 2^15 as well as the negated product.
  localparam int PROD_W = SAMPLE_WIDTH + BETA_W;
  localparam int CMP_W  = SAMPLE_WIDTH + 17;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [BETA_W-1:0] beta;
  logic        [AMP_W-1:0]  amplitude;
  logic signed [BIAS_W-1:0] bias;
  logic        [CONF_W-1:0] peak_confirm_count;
  logic        [HOLD_W-1:0] holdoff_ms;

  logic     cfg_write;
  reg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      beta               <= '0;
      amplitude          <= '0;
      bias               <= '0;
      peak_confirm_count <= PEAK_CONF_RESET;
      holdoff_ms         <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_BETA:      beta               <= pwdata[BETA_W-1:0];
        REG_AMPLITUDE: amplitude          <= pwdata[AMP_W-1:0];
        REG_BIAS:      bias               <= pwdata[BIAS_W-1:0];
        REG_PEAK_CONF: peak_confirm_count <= pwdata[CONF_W-1:0];
        REG_HOLDOFF:   holdoff_ms         <= pwdata[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BETA:      prdata = {{(DATA_W-BETA_W){beta[BETA_W-1]}}, beta};
      REG_AMPLITUDE: prdata = {{(DATA_W-AMP_W){1'b0}}, amplitude};
      REG_BIAS:      prdata = {{(DATA_W-BIAS_W){bias[BIAS_W-1]}}, bias};
      REG_PEAK_CONF: prdata = {{(DATA_W-CONF_W){1'b0}}, peak_confirm_count};
      REG_HOLDOFF:   prdata = {{(DATA_W-HOLD_W){1'b0}}, holdoff_ms};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  logic                           first_sample, first_sample_next;
  logic                           last_high, last_high_next;
  logic signed [SAMPLE_WIDTH-1:0] peak_max, peak_max_next;
  logic signed [SAMPLE_WIDTH-1:0] peak_min, peak_min_next;
  logic                           min_confirmed, min_confirmed_next;
  logic                           max_confirmed, max_confirmed_next;
  logic        [CONF_W-1:0]       confirm_counter, confirm_counter_next;
  logic        [HOLD_W-1:0]       since_switch_ms, since_switch_ms_next;

  logic in_accept;
  logic sample_accept;

  assign in_accept     = in_valid && !in_stall;
  assign sample_accept = in_accept && (cmd_t'(cmd) == CMD_SAMPLE);

  // Confirmation count: bumped on each post-holdoff sample that sets no new peak.
  logic [CONF_W-1:0] count_inc;
  logic              count_done;

  assign count_inc  = confirm_counter + 1'b1;
  assign count_done = (count_inc >= peak_confirm_count);

  // Threshold path. The peak fed to the multiplier is the one after this
  // sample's update, so it is picked from err and the stored peak of the
  // current side ahead of the product.
  logic signed [SAMPLE_WIDTH-1:0] sel_peak;
  logic signed [PROD_W-1:0]       prod;
  logic signed [CMP_W-1:0]        prod_ext;
  logic signed [CMP_W-1:0]        thresh;
  logic signed [CMP_W-1:0]        scaled;

  assign sel_peak = last_high ? ((err > peak_max) ? err : peak_max)
                              : ((err < peak_min) ? err : peak_min);
  assign prod     = beta * sel_peak;
  assign prod_ext = signed'({{(CMP_W-PROD_W){prod[PROD_W-1]}}, prod});
  assign thresh   = -prod_ext;
  assign scaled   = signed'({{2{err[SAMPLE_WIDTH-1]}}, err, 15'd0});

  always_comb begin
    first_sample_next    = first_sample;
    last_high_next       = last_high;
    peak_max_next        = peak_max;
    peak_min_next        = peak_min;
    min_confirmed_next   = min_confirmed;
    max_confirmed_next   = max_confirmed;
    confirm_counter_next = confirm_counter;
    since_switch_ms_next = since_switch_ms;

    if (in_accept) begin
      case (cmd_t'(cmd))
        CMD_TICK: begin
          if (since_switch_ms != HOLD_MAX) begin
            since_switch_ms_next = since_switch_ms + 1'b1;
          end
        end
        CMD_CLEAR: begin
          first_sample_next    = 1'b1;
          last_high_next       = 1'b0;
          peak_max_next        = '0;
          peak_min_next        = '0;
          min_confirmed_next   = 1'b0;
          max_confirmed_next   = 1'b0;
          confirm_counter_next = '0;
        end
        CMD_SAMPLE: begin
          if (first_sample) begin
            // The sign of the first error picks the starting relay side.
            first_sample_next    = 1'b0;
            since_switch_ms_next = '0;
            confirm_counter_next = '0;
            peak_max_next        = '0;
            peak_min_next        = '0;
            last_high_next       = (err > 0);
            max_confirmed_next   = (err > 0);
            min_confirmed_next   = !(err > 0);
          end else if (since_switch_ms > holdoff_ms) begin
            if (!last_high) begin
              // Low side: track the minimum, switch high past -beta*peak_min.
              if (err < peak_min) begin
                peak_min_next        = err;
                confirm_counter_next = '0;
              end else begin
                confirm_counter_next = count_done ? '0 : count_inc;
                if (count_done) begin
                  min_confirmed_next = 1'b1;
                end
                peak_max_next = err;
              end
              if (min_confirmed_next && (scaled > thresh)) begin
                last_high_next       = 1'b1;
                since_switch_ms_next = '0;
                min_confirmed_next   = 1'b0;
              end
            end else begin
              // High side: track the maximum, switch low below -beta*peak_max.
              if (err > peak_max) begin
                peak_max_next        = err;
                confirm_counter_next = '0;
              end else begin
                confirm_counter_next = count_done ? '0 : count_inc;
                if (count_done) begin
                  max_confirmed_next = 1'b1;
                end
                peak_min_next = err;
              end
              if (max_confirmed_next && (scaled < thresh)) begin
                last_high_next       = 1'b0;
                since_switch_ms_next = '0;
                max_confirmed_next   = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample    <= 1'b1;
      last_high       <= 1'b0;
      peak_max        <= '0;
      peak_min        <= '0;
      min_confirmed   <= 1'b0;
      max_confirmed   <= 1'b0;
      confirm_counter <= '0;
      since_switch_ms <= '0;
    end else begin
      first_sample    <= first_sample_next;
      last_high       <= last_high_next;
      peak_max        <= peak_max_next;
      peak_min        <= peak_min_next;
      min_confirmed   <= min_confirmed_next;
      max_confirmed   <= max_confirmed_next;
      confirm_counter <= confirm_counter_next;
      since_switch_ms <= since_switch_ms_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word and output stages
  // ---------------------------------------------------------------------------
  // The command always uses the current amplitude and bias registers.
  logic signed [COMMAND_W-1:0] amp_ext;
  logic signed [COMMAND_W-1:0] bias_ext;
  logic signed [COMMAND_W-1:0] new_command;

  assign amp_ext     = signed'({{(COMMAND_W-AMP_W){1'b0}}, amplitude});
  assign bias_ext    = signed'({bias[BIAS_W-1], bias});
  assign new_command = (last_high_next ? amp_ext : -amp_ext) + bias_ext;

  logic                        skid_valid;
  logic signed [COMMAND_W-1:0] skid_command;
  logic                        skid_relay_high;
  logic                        out_free;

  // The output register can be loaded when empty or when its word is taken.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || sample_accept;
      skid_valid <= 1'b0;
    end else if (sample_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        command    <= skid_command;
        relay_high <= skid_relay_high;
      end else if (sample_accept) begin
        command    <= new_command;
        relay_high <= last_high_next;
      end
    end else if (sample_accept) begin
      skid_command    <= new_command;
      skid_relay_high <= last_high_next;
    end
  end

endmodule

FILE: tb/modified_relay_feedback_controller_tb.sv
// Self-checking testbench for the modified relay feedback controller.
// It predicts every result word from its own model of the relay logic and
// checks the output stream. It depends on mrfc_pkg and the controller RTL.
module modified_relay_feedback_controller_tb;
  import mrfc_pkg::*;

  localparam int SMP_W = 16;
  // Generous cycle budget, far above what a run of about four hundred words
  // needs even under the longest idle bursts.
  localparam int LIMIT = 100000;
  // Command code 3 is not decoded by the block. It must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [SMP_W-1:0] smp;
  } word_t;

  typedef struct packed {
    logic signed [COMMAND_W-1:0] level;
    logic                        hi;
  } relay_out_t;

  logic clk;
  logic rst = 1'b1;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_W-1:0]    paddr   = '0;
  logic [DATA_W-1:0]    pwdata  = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              cmd      = CMD_SAMPLE;
  logic signed [SMP_W-1:0] err      = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [COMMAND_W-1:0] command;
  logic                        relay_high;

  // Words still to be offered, and relay commands still to arrive.
  word_t      words_to_send[$];
  relay_out_t commands_due[$];

  int  fault_count = 0;
  int  cycles      = 0;
  // quiet switches idling off on both sides.
  bit  quiet = 1'b0;
  int  feed_gap = 0;
  int  sink_gap = 0;

  // Our copy of the register file, starting from the documented reset values.
  logic signed [BETA_W-1:0] beta_q   = '0;
  logic [AMP_W-1:0]         amp_q    = '0;
  logic signed [BIAS_W-1:0] bias_q   = '0;
  logic [CONF_W-1:0]        conf_lim = PEAK_CONF_RESET;
  logic [HOLD_W-1:0]        hold_q   = '0;

  // Our copy of the controller state.
  bit                      fresh   = 1'b1;
  bit                      at_high = 1'b0;
  logic signed [SMP_W-1:0] pk_max  = '0;
  logic signed [SMP_W-1:0] pk_min  = '0;
  bit                      min_ok  = 1'b0;
  bit                      max_ok  = 1'b0;
  logic [7:0]              conf_cnt = '0;
  logic [HOLD_W-1:0]       since_ms = '0;

  modified_relay_feedback_controller #(
    .SAMPLE_WIDTH(SMP_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .err        (err),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .command    (command),
    .relay_high (relay_high)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    // The count keeps going, but the log is kept short if the block is badly broken.
    if (fault_count < 50) $display("mismatch at cycle %0d: %s", cycles, what);
    fault_count++;
  endtask

  // A peak counts as confirmed once enough samples have passed it; the
  // counter is eight bits wide and is cleared once it reaches the limit.
  function automatic bit confirm_tick();
    conf_cnt = conf_cnt + 8'd1;
    if (conf_cnt >= conf_lim) begin
      conf_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted word to our controller copy and, for a sample,
  // queues the relay command that the block must produce.
  task automatic advance_relay(input logic [1:0] op, input logic signed [SMP_W-1:0] smp);
    longint     scaled;
    longint     lvl;
    relay_out_t r;
    if (op == CMD_TICK) begin
      if (since_ms != HOLD_MAX) since_ms = since_ms + 1'b1;
    end else if (op == CMD_CLEAR) begin
      // The holdoff timer and the registers survive a controller clear.
      fresh   = 1'b1;
      at_high = 1'b0;
      pk_max  = '0;
      pk_min  = '0;
      min_ok  = 1'b0;
      max_ok  = 1'b0;
      conf_cnt = '0;
    end else if (op == CMD_SAMPLE) begin
      // The threshold compare is exact: err * 2^15 against -(beta * peak).
      scaled = longint'(smp) * 32768;
      if (fresh) begin
        // The first sample only picks the relay side from the error sign;
        // an error of zero counts as not positive.
        fresh    = 1'b0;
        since_ms = '0;
        conf_cnt = '0;
        pk_max   = '0;
        pk_min   = '0;
        at_high  = (smp > 0);
        max_ok   = (smp > 0);
        min_ok   = !(smp > 0);
      end else if (since_ms > hold_q) begin
        if (!at_high) begin
          if (smp < pk_min) begin
            pk_min   = smp;
            conf_cnt = '0;
          end else begin
            if (confirm_tick()) min_ok = 1'b1;
            pk_max = smp;
          end
          if (min_ok && scaled > -(longint'(beta_q) * longint'(pk_min))) begin
            at_high  = 1'b1;
            since_ms = '0;
            min_ok   = 1'b0;
          end
        end else begin
          if (smp > pk_max) begin
            pk_max   = smp;
            conf_cnt = '0;
          end else begin
            if (confirm_tick()) max_ok = 1'b1;
            pk_min = smp;
          end
          if (max_ok && scaled < -(longint'(beta_q) * longint'(pk_max))) begin
            at_high  = 1'b0;
            since_ms = '0;
            max_ok   = 1'b0;
          end
        end
      end
      // The side comes from the relay bit, so a zero amplitude still tells
      // the two sides apart on relay_high.
      lvl = (at_high ? longint'(amp_q) : -longint'(amp_q)) + longint'(bias_q);
      r.level = lvl[COMMAND_W-1:0];
      r.hi    = at_high;
      commands_due.push_back(r);
    end
  endtask

  // Sending side. A word is taken at an edge with in_valid high and in_stall
  // low; a stalled word is held unchanged, and the sender idles in random bursts.
  always @(posedge clk) begin : feed
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_valid && !in_stall) advance_relay(cmd, err);
      if (!(in_valid && in_stall)) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          feed_gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          w = words_to_send.pop_front();
          in_valid <= 1'b1;
          cmd      <= w.op;
          err      <= w.smp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiving side. It checks each taken word against the oldest expected
  // command and stalls in random bursts.
  always @(posedge clk) begin : sink
    relay_out_t e;
    if (rst) begin
      out_stall <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (commands_due.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing expected: command %0d relay_high %b",
                                  command, relay_high));
        end else begin
          e = commands_due.pop_front();
          if (command !== e.level)
            flag_mismatch($sformatf("command %0d, expected %0d", command, e.level));
          if (relay_high !== e.hi)
            flag_mismatch($sformatf("relay_high %b, expected %b", relay_high, e.hi));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void queue_word(input logic [1:0] op, input logic [SMP_W-1:0] smp);
    word_t w;
    w.op  = op;
    w.smp = smp;
    words_to_send.push_back(w);
  endfunction

  // Waits until every word has been taken and every command has arrived,
  // then waits on in case a tick or clear is still in flight.
  task automatic settle();
    while (words_to_send.size() != 0 || in_valid || commands_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One APB write: a setup phase, then an access phase that completes at the
  // edge where pready is high. Our register copy follows the write.
  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BETA:      beta_q   = val[BETA_W-1:0];
      REG_AMPLITUDE: amp_q    = val[AMP_W-1:0];
      REG_BIAS:      bias_q   = val[BIAS_W-1:0];
      REG_PEAK_CONF: conf_lim = val[CONF_W-1:0];
      REG_HOLDOFF:   hold_q   = val[HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic signed [BETA_W-1:0] b, input logic [AMP_W-1:0] a,
                               input logic signed [BIAS_W-1:0] o, input logic [CONF_W-1:0] c,
                               input logic [HOLD_W-1:0] h);
    reg_write(REG_BETA, {{(DATA_W-BETA_W){b[BETA_W-1]}}, b});
    reg_write(REG_AMPLITUDE, {{(DATA_W-AMP_W){1'b0}}, a});
    reg_write(REG_BIAS, {{(DATA_W-BIAS_W){o[BIAS_W-1]}}, o});
    reg_write(REG_PEAK_CONF, {{(DATA_W-CONF_W){1'b0}}, c});
    reg_write(REG_HOLDOFF, {{(DATA_W-HOLD_W){1'b0}}, h});
  endtask

  // Queues an oscillating error: a noisy triangle of random height and
  // period, so that peaks form, get confirmed and the relay switches.
  // Up to three ticks follow each word to let the holdoff run out. Some words are
  // noise: full-range samples, unused codes and, if allowed, controller clears.
  task automatic queue_swing(input int samples, input bit with_clears);
    int span, half, k, ph, level, pick, ticks;
    span = $urandom_range(50, 32000);
    half = $urandom_range(3, 20);
    for (k = 0; k < samples; k++) begin
      pick = $urandom_range(0, 99);
      if (with_clears && pick < 4) begin
        queue_word(CMD_CLEAR, 16'($urandom));
      end else if (pick < 7) begin
        queue_word(CMD_UNUSED, 16'($urandom));
      end else if (pick < 12) begin
        queue_word(CMD_SAMPLE, 16'($urandom));
      end else begin
        ph = k % (2 * half);
        if (ph < half) level = -span + (2 * span * ph) / half;
        else           level = span - (2 * span * (ph - half)) / half;
        level += $urandom_range(0, 64) - 32;
        if (level > 32767)  level = 32767;
        if (level < -32768) level = -32768;
        queue_word(CMD_SAMPLE, level[SMP_W-1:0]);
      end
      ticks = $urandom_range(0, 3);
      repeat (ticks) queue_word(CMD_TICK, 16'($urandom));
    end
  endtask

  initial begin : run
    int ph;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset register values: zero amplitude and bias,
    // so only relay_high moves. A first sample of zero picks the low side, field
    // extremes come while the holdoff freezes the peaks, and a tick, an unused
    // code and a clear come before a positive first sample picks the high side.
    queue_word(CMD_SAMPLE, 16'sd0);
    queue_word(CMD_SAMPLE, 16'sd1);
    queue_word(CMD_SAMPLE, -16'sd32768);
    queue_word(CMD_SAMPLE, -16'sd1);
    queue_word(CMD_SAMPLE, 16'sd32767);
    queue_word(CMD_SAMPLE, 16'sd32767);
    queue_word(CMD_SAMPLE, 16'sd0);
    queue_word(CMD_TICK, 16'hFFFF);
    queue_word(CMD_UNUSED, 16'h8001);
    queue_word(CMD_CLEAR, 16'h7FFE);
    queue_word(CMD_SAMPLE, 16'sd32767);
    queue_word(CMD_SAMPLE, -16'sd32768);
    queue_word(CMD_SAMPLE, 16'sd1);
    queue_word(CMD_SAMPLE, 16'sd1);
    queue_word(CMD_SAMPLE, -16'sd32768);
    queue_word(CMD_CLEAR, 16'h0000);
    queue_word(CMD_SAMPLE, -16'sd1);
    settle();

    // Random phases under changing settings, the extremes among them. The
    // state is carried across, so a new amplitude or bias shows at once.
    // Each phase ends with the sender waiting until every command is in.
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_setting(16'sd16384, 15'd1000, -16'sd200, 8'd2, 16'd0);
        1: apply_setting(-16'sd32768, 15'd32767, 16'sd32767, 8'd0, 16'd3);
        2: apply_setting(16'sd32767, 15'd32767, -16'sd32768, 8'd255, 16'd0);
        3: apply_setting(16'sd0, 15'd0, 16'sd0, 8'd1, 16'd0);
        4: apply_setting(-16'sd16384, 15'd500, 16'sd100, 8'd3, 16'd10);
        default: apply_setting(16'($urandom), 15'($urandom), 16'($urandom),
                               8'($urandom_range(0, 6)), 16'($urandom_range(0, 12)));
      endcase
      queue_swing(15, 1'b1);
      settle();
    end

    // Holdoff at its maximum: after a first sample the timer can never pass
    // the limit, so the relay must stay put however the error swings.
    apply_setting(16'sd16384, 15'd2000, 16'sd0, 8'd1, HOLD_MAX);
    queue_word(CMD_CLEAR, 16'h0000);
    queue_word(CMD_SAMPLE, -16'sd500);
    queue_swing(10, 1'b0);
    settle();

    // One below the maximum: the few ticks stay far short of it, so the
    // relay still holds its side.
    reg_write(REG_HOLDOFF, 32'd65534);
    queue_swing(10, 1'b0);
    settle();

    // Closing phase with no idling on either side.
    quiet = 1'b1;
    apply_setting(16'($urandom), 15'($urandom), 16'($urandom), 8'($urandom_range(0, 4)),
                  16'($urandom_range(0, 4)));
    queue_swing(25, 1'b1);
    settle();

    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
